[sv/ikl_pkg.sv]
package ikl_pkg;

  // fixed-point setup
  localparam int FRAC_BITS     = 12;
  localparam int CORDIC_STAGES = 16;
  localparam int ANG_FRAC      = FRAC_BITS + 1;
  localparam int ANG_SHIFT     = 30 - ANG_FRAC;
  localparam int TAB_LEN       = 24;
  localparam int CORDIC_N      = (CORDIC_STAGES < TAB_LEN) ? CORDIC_STAGES : TAB_LEN;

  // widths
  localparam int LEN_W = 15;
  localparam int IN_W  = 16;
  localparam int ANG_W = 16;
  localparam int SQ_W  = 62;
  localparam int REM_W = 33;
  localparam int DEN_W = 31;
  localparam int Q_W   = 31;
  localparam int CW    = 50;
  localparam int ZW    = 35;
  localparam int AW    = 36;
  localparam int IDX_W = 2;

  // pipeline depths of the iterative units
  localparam int SQ1_N = 16;
  localparam int DIV_N = 31;
  localparam int SQ2_N = 31;

  localparam logic signed [ZW-1:0] PI_Q30 = 35'sd3373259426;

  // register indexes
  localparam logic [IDX_W-1:0] REG_COXA  = 2'd0;
  localparam logic [IDX_W-1:0] REG_FEMUR = 2'd1;
  localparam logic [IDX_W-1:0] REG_TIBIA = 2'd2;

  localparam logic [LEN_W-1:0] COXA_RST  = 15'd4096;
  localparam logic [LEN_W-1:0] FEMUR_RST = 15'd6554;
  localparam logic [LEN_W-1:0] TIBIA_RST = 15'd8192;

  typedef struct packed {
    logic signed [IN_W-1:0] target_x;
    logic signed [IN_W-1:0] target_y;
    logic signed [IN_W-1:0] target_z;
  } ikl_in_t;

  typedef struct packed {
    logic signed [ANG_W-1:0] coxa_angle;
    logic signed [ANG_W-1:0] femur_angle;
    logic signed [ANG_W-1:0] tibia_angle;
    logic                    out_of_reach;
  } ikl_out_t;

  // values that ride along the pipeline
  typedef struct packed {
    logic signed [IN_W-1:0] x;
    logic signed [IN_W-1:0] y;
    logic signed [IN_W-1:0] z;
    logic signed [17:0]     r;
    logic                   flag;
    logic                   dz;
    logic                   neg;
    logic signed [31:0]     c;
    logic [30:0]            s;
  } ikl_carry_t;

  // arctangent of 2^-i with 30 fraction bits
  function automatic logic signed [ZW-1:0] atan_val(input int unsigned i);
    logic [31:0] v;
    unique case (i)
      0:  v = 32'h3243F6A8;
      1:  v = 32'h1DAC6705;
      2:  v = 32'h0FADBAFC;
      3:  v = 32'h07F56EA6;
      4:  v = 32'h03FEAB76;
      5:  v = 32'h01FFD55B;
      6:  v = 32'h00FFFAAA;
      7:  v = 32'h007FFF55;
      8:  v = 32'h003FFFEA;
      9:  v = 32'h001FFFFD;
      10: v = 32'h000FFFFF;
      11: v = 32'h0007FFFF;
      12: v = 32'h0003FFFF;
      13: v = 32'h0001FFFF;
      14: v = 32'h0000FFFF;
      15: v = 32'h00007FFF;
      16: v = 32'h00003FFF;
      17: v = 32'h00001FFF;
      18: v = 32'h00000FFF;
      19: v = 32'h000007FF;
      20: v = 32'h000003FF;
      21: v = 32'h000001FF;
      22: v = 32'h000000FF;
      23: v = 32'h0000007F;
      default: v = 32'h0;
    endcase
    return $signed(ZW'(v));
  endfunction

endpackage

[sv/ikl_sqrt_step.sv]
// one digit of a restoring integer square root
module ikl_sqrt_step (
  input  logic [ikl_pkg::SQ_W-1:0] v_i,
  input  logic [ikl_pkg::SQ_W-1:0] res_i,
  input  logic [ikl_pkg::SQ_W-1:0] bit_i,
  output logic [ikl_pkg::SQ_W-1:0] v_o,
  output logic [ikl_pkg::SQ_W-1:0] res_o
);

  logic [ikl_pkg::SQ_W-1:0] trial;
  logic                     ge;

  always_comb begin
    trial = res_i + bit_i;
    ge    = (v_i >= trial);
    v_o   = ge ? (v_i - trial) : v_i;
    res_o = ge ? ((res_i >> 1) + bit_i) : (res_i >> 1);
  end

endmodule

[sv/ikl_div_step.sv]
// one quotient bit of a restoring divider
module ikl_div_step (
  input  logic [ikl_pkg::REM_W-1:0] rem_i,
  input  logic [ikl_pkg::DEN_W-1:0] den_i,
  output logic                      ge_o,
  output logic [ikl_pkg::REM_W-1:0] rem_o
);

  logic [ikl_pkg::REM_W-1:0] den_ext;

  always_comb begin
    den_ext = ikl_pkg::REM_W'(den_i);
    ge_o    = (rem_i >= den_ext);
    rem_o   = ge_o ? (rem_i - den_ext) : rem_i;
  end

endmodule

[sv/ikl_cordic_step.sv]
// one vectoring rotation, shifts round toward minus infinity
module ikl_cordic_step (
  input  logic signed [ikl_pkg::CW-1:0] x_i,
  input  logic signed [ikl_pkg::CW-1:0] y_i,
  input  logic signed [ikl_pkg::ZW-1:0] z_i,
  input  logic [4:0]                    sh_i,
  input  logic signed [ikl_pkg::ZW-1:0] atan_i,
  output logic signed [ikl_pkg::CW-1:0] x_o,
  output logic signed [ikl_pkg::CW-1:0] y_o,
  output logic signed [ikl_pkg::ZW-1:0] z_o
);

  logic signed [ikl_pkg::CW-1:0] dx;
  logic signed [ikl_pkg::CW-1:0] dy;

  always_comb begin
    dx = y_i >>> sh_i;
    dy = x_i >>> sh_i;
    if (!y_i[ikl_pkg::CW-1]) begin
      x_o = x_i + dx;
      y_o = y_i - dy;
      z_o = z_i + atan_i;
    end else begin
      x_o = x_i - dx;
      y_o = y_i + dy;
      z_o = z_i - atan_i;
    end
  end

endmodule

[sv/leg_inverse_kinematics_3dof_core.sv]
// Three-joint leg inverse kinematics. A foot target (x, y, z, Q4.12) is taken
// whenever start is high (busy is always low) and, once it has passed the pipeline,
// res_valid_o pulses for one cycle with the coxa, femur and tibia angles
// (Q3.13 radians) and the out-of-reach flag. The receiver cannot stall, so
// results must be taken in that cycle. One new target may enter every cycle;
// the latency is set by the two bit-per-stage square roots, the bit-per-stage
// divider and the CORDIC pipelines. The user must write segment lengths
// through the cfg channel (always ready) only while no target is in flight;
// the block itself does not enforce this.
module leg_inverse_kinematics_3dof_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start,
  output logic                         busy,
  input  ikl_pkg::ikl_in_t             target_i,
  output logic                         res_valid_o,
  output ikl_pkg::ikl_out_t            result_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [ikl_pkg::IDX_W-1:0]    cfg_index_i,
  input  logic [ikl_pkg::LEN_W-1:0]    cfg_data_i
);

  localparam int NC = ikl_pkg::CORDIC_N;

  // ---------------- configuration registers ----------------
  logic [ikl_pkg::LEN_W-1:0] len_c_q, len_f_q, len_t_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_c_q <= ikl_pkg::COXA_RST;
      len_f_q <= ikl_pkg::FEMUR_RST;
      len_t_q <= ikl_pkg::TIBIA_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        ikl_pkg::REG_COXA:  len_c_q <= cfg_data_i;
        ikl_pkg::REG_FEMUR: len_f_q <= cfg_data_i;
        ikl_pkg::REG_TIBIA: len_t_q <= cfg_data_i;
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // ---------------- front: input beat, squares, sum ----------------
  logic                   v0_q, v1_q;
  ikl_pkg::ikl_in_t       in_q;
  ikl_pkg::ikl_carry_t    cr1_q;
  logic [31:0]            xx1_q, yy1_q;

  // square root of x^2 + y^2
  logic                     sq1_vld_q [0:ikl_pkg::SQ1_N];
  logic [ikl_pkg::SQ_W-1:0] sq1_v_q   [0:ikl_pkg::SQ1_N];
  logic [ikl_pkg::SQ_W-1:0] sq1_r_q   [0:ikl_pkg::SQ1_N];
  ikl_pkg::ikl_carry_t      sq1_cr_q  [0:ikl_pkg::SQ1_N];

  logic signed [31:0] px, py;
  ikl_pkg::ikl_carry_t cr1_d;

  always_comb begin
    px    = 32'(in_q.target_x) * 32'(in_q.target_x);
    py    = 32'(in_q.target_y) * 32'(in_q.target_y);
    cr1_d = '0;
    cr1_d.x = in_q.target_x;
    cr1_d.y = in_q.target_y;
    cr1_d.z = in_q.target_z;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q          <= 1'b0;
      v1_q          <= 1'b0;
      sq1_vld_q[0]  <= 1'b0;
    end else begin
      v0_q          <= start && !busy;
      v1_q          <= v0_q;
      sq1_vld_q[0]  <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    in_q        <= target_i;
    cr1_q       <= cr1_d;
    xx1_q       <= px;
    yy1_q       <= py;
    sq1_v_q[0]  <= ikl_pkg::SQ_W'(xx1_q) + ikl_pkg::SQ_W'(yy1_q);
    sq1_r_q[0]  <= '0;
    sq1_cr_q[0] <= cr1_q;
  end

  for (genvar k = 0; k < ikl_pkg::SQ1_N; k++) begin : g_sq1
    localparam logic [ikl_pkg::SQ_W-1:0] BITV = ikl_pkg::SQ_W'(1) << (30 - 2 * k);
    logic [ikl_pkg::SQ_W-1:0] v_n, r_n;

    ikl_sqrt_step u_step (
      .v_i  (sq1_v_q[k]),
      .res_i(sq1_r_q[k]),
      .bit_i(BITV),
      .v_o  (v_n),
      .res_o(r_n)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq1_vld_q[k+1] <= 1'b0;
      end else begin
        sq1_vld_q[k+1] <= sq1_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq1_v_q[k+1]  <= v_n;
      sq1_r_q[k+1]  <= r_n;
      sq1_cr_q[k+1] <= sq1_cr_q[k];
    end
  end

  // ---------------- law of cosines numerator and denominator ----------------
  logic                v3_q, v4_q, v5_q;
  ikl_pkg::ikl_carry_t cr3_q, cr4_q, cr5_q;
  logic [31:0]         rr4_q;
  logic [30:0]         zz4_q;
  logic [29:0]         ff4_q, tt4_q;
  logic [ikl_pkg::DEN_W-1:0] den4_q, den5_q;
  logic signed [34:0]  num5_q;

  ikl_pkg::ikl_carry_t cr3_d;
  logic signed [35:0]  prr;
  logic signed [31:0]  pzz;
  logic signed [34:0]  num5_d;

  always_comb begin
    cr3_d   = sq1_cr_q[ikl_pkg::SQ1_N];
    // horizontal reach minus the coxa
    cr3_d.r = $signed({2'b00, sq1_r_q[ikl_pkg::SQ1_N][15:0]}) - $signed({3'b000, len_c_q});
    prr     = 36'(cr3_q.r) * 36'(cr3_q.r);
    pzz     = 32'(cr3_q.z) * 32'(cr3_q.z);
    num5_d  = $signed(35'(rr4_q)) + $signed(35'(zz4_q))
            - $signed(35'(ff4_q)) - $signed(35'(tt4_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v3_q <= sq1_vld_q[ikl_pkg::SQ1_N];
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cr3_q  <= cr3_d;
    cr4_q  <= cr3_q;
    rr4_q  <= prr[31:0];
    zz4_q  <= pzz[30:0];
    ff4_q  <= 30'(len_f_q) * 30'(len_f_q);
    tt4_q  <= 30'(len_t_q) * 30'(len_t_q);
    den4_q <= {(30'(len_f_q) * 30'(len_t_q)), 1'b0};
    cr5_q  <= cr4_q;
    num5_q <= num5_d;
    den5_q <= den4_q;
  end

  // ---------------- cosine ratio divider ----------------
  logic                      div_vld_q [0:ikl_pkg::DIV_N];
  logic [ikl_pkg::REM_W-1:0] div_rem_q [0:ikl_pkg::DIV_N];
  logic [ikl_pkg::Q_W-1:0]   div_q_q   [0:ikl_pkg::DIV_N];
  logic [ikl_pkg::DEN_W-1:0] div_den_q [0:ikl_pkg::DIV_N];
  ikl_pkg::ikl_carry_t       div_cr_q  [0:ikl_pkg::DIV_N];

  logic [34:0]               mag_w;
  logic [ikl_pkg::REM_W-1:0] mag;
  ikl_pkg::ikl_carry_t       cr6_d;

  always_comb begin
    mag_w     = num5_q[34] ? 35'(-num5_q) : 35'(num5_q);
    mag       = mag_w[ikl_pkg::REM_W-1:0];
    cr6_d     = cr5_q;
    cr6_d.neg = num5_q[34];
    cr6_d.flag = (mag > ikl_pkg::REM_W'(den5_q));
    cr6_d.dz  = (den5_q == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_vld_q[0] <= 1'b0;
    end else begin
      div_vld_q[0] <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    div_rem_q[0] <= mag;
    div_q_q[0]   <= '0;
    div_den_q[0] <= den5_q;
    div_cr_q[0]  <= cr6_d;
  end

  for (genvar k = 0; k < ikl_pkg::DIV_N; k++) begin : g_div
    logic [ikl_pkg::REM_W-1:0] rem_in, rem_n;
    logic                      ge;

    // first step weighs the integer bit, later steps bring in a zero
    if (k == 0) begin : g_first
      assign rem_in = div_rem_q[k];
    end else begin : g_next
      assign rem_in = {div_rem_q[k][ikl_pkg::REM_W-2:0], 1'b0};
    end

    ikl_div_step u_step (
      .rem_i(rem_in),
      .den_i(div_den_q[k]),
      .ge_o (ge),
      .rem_o(rem_n)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        div_vld_q[k+1] <= 1'b0;
      end else begin
        div_vld_q[k+1] <= div_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      div_rem_q[k+1] <= rem_n;
      div_q_q[k+1]   <= {div_q_q[k][ikl_pkg::Q_W-2:0], ge};
      div_den_q[k+1] <= div_den_q[k];
      div_cr_q[k+1]  <= div_cr_q[k];
    end
  end

  // ---------------- clamp, sine magnitude ----------------
  logic                    v7_q, v8_q;
  ikl_pkg::ikl_carry_t     cr7_q, cr8_q;
  logic [ikl_pkg::Q_W-1:0] cmag7_q;
  logic [61:0]             csq8_q;

  ikl_pkg::ikl_carry_t     cr7_d;
  logic [ikl_pkg::Q_W-1:0] cmag;
  ikl_pkg::ikl_carry_t     dlast;

  always_comb begin
    dlast = div_cr_q[ikl_pkg::DIV_N];
    // unreachable pins the ratio at one, zero denominator gives zero
    if (dlast.flag) begin
      cmag = ikl_pkg::Q_W'(1) << 30;
    end else if (dlast.dz) begin
      cmag = '0;
    end else begin
      cmag = div_q_q[ikl_pkg::DIV_N];
    end
    cr7_d   = dlast;
    cr7_d.c = dlast.neg ? -$signed(32'(cmag)) : $signed(32'(cmag));
  end

  logic                     sq2_vld_q [0:ikl_pkg::SQ2_N];
  logic [ikl_pkg::SQ_W-1:0] sq2_v_q   [0:ikl_pkg::SQ2_N];
  logic [ikl_pkg::SQ_W-1:0] sq2_r_q   [0:ikl_pkg::SQ2_N];
  ikl_pkg::ikl_carry_t      sq2_cr_q  [0:ikl_pkg::SQ2_N];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q         <= 1'b0;
      v8_q         <= 1'b0;
      sq2_vld_q[0] <= 1'b0;
    end else begin
      v7_q         <= div_vld_q[ikl_pkg::DIV_N];
      v8_q         <= v7_q;
      sq2_vld_q[0] <= v8_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cr7_q       <= cr7_d;
    cmag7_q     <= cmag;
    cr8_q       <= cr7_q;
    csq8_q      <= 62'(cmag7_q) * 62'(cmag7_q);
    sq2_v_q[0]  <= (ikl_pkg::SQ_W'(1) << 60) - csq8_q;
    sq2_r_q[0]  <= '0;
    sq2_cr_q[0] <= cr8_q;
  end

  for (genvar k = 0; k < ikl_pkg::SQ2_N; k++) begin : g_sq2
    localparam logic [ikl_pkg::SQ_W-1:0] BITV = ikl_pkg::SQ_W'(1) << (60 - 2 * k);
    logic [ikl_pkg::SQ_W-1:0] v_n, r_n;

    ikl_sqrt_step u_step (
      .v_i  (sq2_v_q[k]),
      .res_i(sq2_r_q[k]),
      .bit_i(BITV),
      .v_o  (v_n),
      .res_o(r_n)
    );

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq2_vld_q[k+1] <= 1'b0;
      end else begin
        sq2_vld_q[k+1] <= sq2_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      sq2_v_q[k+1]  <= v_n;
      sq2_r_q[k+1]  <= r_n;
      sq2_cr_q[k+1] <= sq2_cr_q[k];
    end
  end

  // ---------------- knee vector: F + T sin, T cos ----------------
  logic                v10_q, v11_q;
  ikl_pkg::ikl_carry_t cr10_q, cr11_q;
  logic [45:0]         ts10_q;
  logic signed [47:0]  tc10_q, bb11_q;
  logic [46:0]         ba11_q;

  ikl_pkg::ikl_carry_t cr10_d;

  always_comb begin
    cr10_d   = sq2_cr_q[ikl_pkg::SQ2_N];
    cr10_d.s = sq2_r_q[ikl_pkg::SQ2_N][30:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v10_q <= 1'b0;
      v11_q <= 1'b0;
    end else begin
      v10_q <= sq2_vld_q[ikl_pkg::SQ2_N];
      v11_q <= v10_q;
    end
  end

  always_ff @(posedge clk_i) begin
    cr10_q <= cr10_d;
    ts10_q <= 46'(len_t_q) * 46'(cr10_d.s);
    tc10_q <= 48'($signed({1'b0, len_t_q})) * 48'(cr10_d.c);
    cr11_q <= cr10_q;
    ba11_q <= (47'(len_f_q) << 30) + 47'(ts10_q);
    bb11_q <= tc10_q;
  end

  // ---------------- four CORDIC vectoring pipelines ----------------
  // unit 0: atan2(y, x), 1: atan2(c, s), 2: atan2(r, z), 3: atan2(A, B)
  logic signed [ikl_pkg::CW-1:0] uy [0:3];
  logic signed [ikl_pkg::CW-1:0] ux [0:3];

  always_comb begin
    uy[0] = ikl_pkg::CW'(cr11_q.y);
    ux[0] = ikl_pkg::CW'(cr11_q.x);
    uy[1] = ikl_pkg::CW'(cr11_q.c);
    ux[1] = ikl_pkg::CW'($signed({1'b0, cr11_q.s}));
    uy[2] = ikl_pkg::CW'(cr11_q.r);
    ux[2] = ikl_pkg::CW'(cr11_q.z);
    uy[3] = ikl_pkg::CW'($signed({1'b0, ba11_q}));
    ux[3] = ikl_pkg::CW'(bb11_q);
  end

  logic                          co_vld_q  [0:NC];
  logic                          co_flag_q [0:NC];
  logic signed [ikl_pkg::CW-1:0] cx_q      [0:3][0:NC];
  logic signed [ikl_pkg::CW-1:0] cy_q      [0:3][0:NC];
  logic signed [ikl_pkg::ZW-1:0] cz_q      [0:3][0:NC];
  logic                          czero_q   [0:3][0:NC];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      co_vld_q[0] <= 1'b0;
    end else begin
      co_vld_q[0] <= v11_q;
    end
  end

  always_ff @(posedge clk_i) begin
    co_flag_q[0] <= cr11_q.flag;
  end

  for (genvar u = 0; u < 4; u++) begin : g_unit
    // left half plane is folded over by a half turn
    always_ff @(posedge clk_i) begin
      czero_q[u][0] <= (ux[u] == '0) && (uy[u] == '0);
      if (ux[u][ikl_pkg::CW-1]) begin
        cx_q[u][0] <= -ux[u];
        cy_q[u][0] <= -uy[u];
        cz_q[u][0] <= uy[u][ikl_pkg::CW-1] ? -ikl_pkg::PI_Q30 : ikl_pkg::PI_Q30;
      end else begin
        cx_q[u][0] <= ux[u];
        cy_q[u][0] <= uy[u];
        cz_q[u][0] <= '0;
      end
    end

    for (genvar k = 0; k < NC; k++) begin : g_rot
      logic signed [ikl_pkg::CW-1:0] x_n, y_n;
      logic signed [ikl_pkg::ZW-1:0] z_n;

      ikl_cordic_step u_step (
        .x_i   (cx_q[u][k]),
        .y_i   (cy_q[u][k]),
        .z_i   (cz_q[u][k]),
        .sh_i  (5'(k)),
        .atan_i(ikl_pkg::atan_val(k)),
        .x_o   (x_n),
        .y_o   (y_n),
        .z_o   (z_n)
      );

      always_ff @(posedge clk_i) begin
        cx_q[u][k+1]    <= x_n;
        cy_q[u][k+1]    <= y_n;
        cz_q[u][k+1]    <= z_n;
        czero_q[u][k+1] <= czero_q[u][k];
      end
    end
  end

  for (genvar k = 0; k < NC; k++) begin : g_cside
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        co_vld_q[k+1] <= 1'b0;
      end else begin
        co_vld_q[k+1] <= co_vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      co_flag_q[k+1] <= co_flag_q[k];
    end
  end

  // ---------------- angle assembly and output rounding ----------------
  logic signed [ikl_pkg::AW-1:0] ang_q [0:3];
  logic signed [ikl_pkg::AW-1:0] ang_d [0:3];
  logic                          v12_q, flag12_q;
  logic                          res_valid_q;
  ikl_pkg::ikl_out_t             result_q;

  always_comb begin
    for (int u = 0; u < 4; u++) begin
      ang_d[u] = czero_q[u][NC] ? '0 : ikl_pkg::AW'(cz_q[u][NC]);
    end
  end

  // round half up to the output grid, then saturate
  function automatic logic signed [ikl_pkg::ANG_W-1:0] ang_out(
    input logic signed [ikl_pkg::AW-1:0] a
  );
    logic signed [ikl_pkg::AW-1:0] t;
    t = (a + (ikl_pkg::AW'(1) <<< (ikl_pkg::ANG_SHIFT - 1))) >>> ikl_pkg::ANG_SHIFT;
    if (t > ikl_pkg::AW'(32767)) begin
      return 16'sd32767;
    end else if (t < -ikl_pkg::AW'(32768)) begin
      return -16'sd32768;
    end else begin
      return t[ikl_pkg::ANG_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v12_q       <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      v12_q       <= co_vld_q[NC];
      res_valid_q <= v12_q;
    end
  end

  always_ff @(posedge clk_i) begin
    flag12_q <= co_flag_q[NC];
    ang_q[0] <= ang_d[0];
    ang_q[1] <= ang_d[1];
    ang_q[2] <= ang_d[2] - ang_d[3];  // femur
    ang_q[3] <= '0;
    result_q.coxa_angle   <= ang_out(ang_q[0]);
    result_q.femur_angle  <= ang_out(ang_q[2]);
    result_q.tibia_angle  <= ang_out(ang_q[1] + ang_q[3]);
    result_q.out_of_reach <= flag12_q;
  end

  assign res_valid_o = res_valid_q;
  assign result_o    = result_q;

`ifndef ASSERT_OFF
  // a clamped ratio leaves the tibia near plus or minus a quarter turn
  a_reach_tibia : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && result_o.out_of_reach) |->
      (result_o.tibia_angle > 16'sd12800 || result_o.tibia_angle < -16'sd12800))
    else $error("out of reach without a straight knee");

  // an unclamped quotient never exceeds one
  a_div_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_vld_q[ikl_pkg::DIV_N] && !div_cr_q[ikl_pkg::DIV_N].flag
      && !div_cr_q[ikl_pkg::DIV_N].dz) |->
      (div_q_q[ikl_pkg::DIV_N] <= (ikl_pkg::Q_W'(1) << 30)))
    else $error("cosine ratio above one");

  // sine magnitude stays within one
  a_sin_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq2_vld_q[ikl_pkg::SQ2_N] |->
      (sq2_r_q[ikl_pkg::SQ2_N] <= (ikl_pkg::SQ_W'(1) << 30)))
    else $error("sine magnitude above one");
`endif

endmodule
